/* design/rlse_pkg.sv */
// Shared constants, control codes and interface types for the RGB LED SPI frame encoder.
package rlse_pkg;

  // LED channel store
  localparam int CHANNELS = 12;
  localparam int NODES    = CHANNELS / 3;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int NODE_W   = (NODES > 1) ? $clog2(NODES) : 1;

  // operation codes on the input stream
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_SEND  = 2'd2;

  // datapath actions issued by the microcode
  localparam logic [2:0] A_NONE  = 3'd0;
  localparam logic [2:0] A_FETCH = 3'd1;
  localparam logic [2:0] A_WRITE = 3'd2;
  localparam logic [2:0] A_TICK  = 3'd3;
  localparam logic [2:0] A_PAINT = 3'd4;
  localparam logic [2:0] A_SEND  = 3'd5;
  localparam logic [2:0] A_EMIT  = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_HOLD = 3'd0;
  localparam logic [2:0] REG_PAL0 = 3'd1;
  localparam logic [2:0] REG_PAL1 = 3'd2;
  localparam logic [2:0] REG_PAL2 = 3'd3;
  localparam logic [2:0] REG_PAL3 = 3'd4;

  localparam logic [15:0] HOLD_RST = 16'd8;
  localparam logic [23:0] PAL0_RST = 24'h323232;
  localparam logic [23:0] PAL1_RST = 24'h640000;
  localparam logic [23:0] PAL2_RST = 24'h000064;
  localparam logic [23:0] PAL3_RST = 24'h006400;

  typedef logic [3:0][23:0] palette_t;

  typedef struct packed {
    logic [2:0] act;
  } ctrl_t;

  typedef struct packed {
    logic accepted;
    logic op_write;
    logic op_tick;
    logic paint_due;
    logic send_go;
    logic paint_last;
    logic emit_done;
  } status_t;

endpackage

/* design/rlse_sequencer.sv */
// Microcode sequencer: step counter, control store and jump condition select.
module rlse_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  rlse_pkg::status_t status,
  output rlse_pkg::ctrl_t   ctrl
);
  import rlse_pkg::*;

  // step addresses
  localparam logic [2:0] P_FETCH  = 3'd0;
  localparam logic [2:0] P_DECODE = 3'd1;
  localparam logic [2:0] P_WRITE  = 3'd2;
  localparam logic [2:0] P_TEST   = 3'd3;
  localparam logic [2:0] P_TICK   = 3'd4;
  localparam logic [2:0] P_SEND   = 3'd5;
  localparam logic [2:0] P_PAINT  = 3'd6;
  localparam logic [2:0] P_EMIT   = 3'd7;

  // jump conditions
  localparam logic [2:0] C_ALWAYS     = 3'd0;
  localparam logic [2:0] C_ACCEPTED   = 3'd1;
  localparam logic [2:0] C_OP_WRITE   = 3'd2;
  localparam logic [2:0] C_OP_TICK    = 3'd3;
  localparam logic [2:0] C_PAINT_DUE  = 3'd4;
  localparam logic [2:0] C_SEND_GO    = 3'd5;
  localparam logic [2:0] C_PAINT_LAST = 3'd6;
  localparam logic [2:0] C_EMIT_DONE  = 3'd7;

  typedef struct packed {
    logic [2:0] act;
    logic [2:0] cond;
    logic [2:0] tgt_t;
    logic [2:0] tgt_f;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [2:0] addr);
    uword_t w;
    unique case (addr)
      P_FETCH:  w = '{A_FETCH, C_ACCEPTED,   P_DECODE, P_FETCH};
      P_DECODE: w = '{A_NONE,  C_OP_WRITE,   P_WRITE,  P_TEST};
      P_WRITE:  w = '{A_WRITE, C_ALWAYS,     P_FETCH,  P_FETCH};
      P_TEST:   w = '{A_NONE,  C_OP_TICK,    P_TICK,   P_SEND};
      P_TICK:   w = '{A_TICK,  C_PAINT_DUE,  P_PAINT,  P_FETCH};
      P_SEND:   w = '{A_SEND,  C_SEND_GO,    P_EMIT,   P_FETCH};
      P_PAINT:  w = '{A_PAINT, C_PAINT_LAST, P_FETCH,  P_PAINT};
      P_EMIT:   w = '{A_EMIT,  C_EMIT_DONE,  P_FETCH,  P_EMIT};
    endcase
    return w;
  endfunction

  logic [2:0] pc;
  logic [2:0] pc_next;
  uword_t     uw;
  logic       hit;

  always_comb begin
    uw = ucode_rom(pc);
    unique case (uw.cond)
      C_ALWAYS:     hit = 1'b1;
      C_ACCEPTED:   hit = status.accepted;
      C_OP_WRITE:   hit = status.op_write;
      C_OP_TICK:    hit = status.op_tick;
      C_PAINT_DUE:  hit = status.paint_due;
      C_SEND_GO:    hit = status.send_go;
      C_PAINT_LAST: hit = status.paint_last;
      C_EMIT_DONE:  hit = status.emit_done;
    endcase
    pc_next  = hit ? uw.tgt_t : uw.tgt_f;
    ctrl.act = uw.act;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* design/rlse_datapath.sv */
// Datapath: level store, animator counters, symbol encoder and output register.
module rlse_datapath (
  input  logic               clk,
  input  logic               rst,
  input  rlse_pkg::ctrl_t    ctrl,
  output rlse_pkg::status_t  status,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [1:0]         s_tuser,
  input  logic [15:0]        s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tlast,
  input  logic [15:0]        hold_ticks,
  input  rlse_pkg::palette_t palette
);
  import rlse_pkg::*;

  // 3-bit symbols: 100 for a 0, 110 for a 1, msb first
  function automatic logic [23:0] encode_level(input logic [7:0] lv);
    logic [23:0] code;
    code = 24'h924924;
    for (int b = 0; b < 8; b++) begin
      code[3*b+1] = lv[b];
    end
    return code;
  endfunction

  logic [7:0]        levels [CHANNELS];
  logic [1:0]        op;
  logic [4:0]        chan;
  logic [7:0]        lvl;
  logic              changed;
  logic              started;
  logic [1:0]        phase;
  logic [15:0]       hold_count;
  logic [CH_W-1:0]   ch_idx;
  logic [NODE_W-1:0] node;
  logic [1:0]        sub;
  logic              out_valid;
  logic [7:0]        out_data;
  logic              out_last;

  logic        accept;
  logic [15:0] cnt_inc;
  logic        tick_due;
  logic [1:0]  pal_sel;
  logic [23:0] colour;
  logic [7:0]  paint_lvl;
  logic [23:0] code;
  logic [7:0]  emit_byte;
  logic        load;
  logic        paint_last;
  logic        emit_last;

  always_comb begin
    s_tready = (ctrl.act == A_FETCH);
    accept   = s_tvalid & s_tready;
    cnt_inc  = hold_count + 16'd1;
    tick_due = !started || (cnt_inc >= hold_ticks);
    pal_sel  = phase + 2'(node);
    colour   = palette[pal_sel];
    code     = encode_level(levels[ch_idx]);
    unique case (sub)
      2'd0:    paint_lvl = colour[15:8];   // green
      2'd1:    paint_lvl = colour[23:16];  // red
      default: paint_lvl = colour[7:0];    // blue
    endcase
    unique case (sub)
      2'd0:    emit_byte = code[23:16];
      2'd1:    emit_byte = code[15:8];
      default: emit_byte = code[7:0];
    endcase
    load       = !out_valid || m_tready;
    paint_last = (node == NODE_W'(NODES - 1)) && (sub == 2'd2);
    emit_last  = (ch_idx == CH_W'(CHANNELS - 1)) && (sub == 2'd2);

    status.accepted   = accept;
    status.op_write   = (op == OP_WRITE);
    status.op_tick    = (op == OP_TICK);
    status.paint_due  = tick_due;
    status.send_go    = (op == OP_SEND) && changed;
    status.paint_last = paint_last;
    status.emit_done  = load && emit_last;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        levels[i] <= 8'd0;
      end
      changed    <= 1'b0;
      started    <= 1'b0;
      phase      <= 2'd0;
      hold_count <= 16'd0;
      ch_idx     <= '0;
      node       <= '0;
      sub        <= 2'd0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        op   <= s_tuser;
        chan <= s_tdata[4:0];
        lvl  <= s_tdata[12:5];
      end
      // the emit step reloads the register itself
      if (out_valid && m_tready && (ctrl.act != A_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.act)
        A_WRITE: begin
          if (chan < 5'(CHANNELS)) begin
            levels[chan[CH_W-1:0]] <= lvl;
            changed                <= 1'b1;
          end
        end
        A_TICK: begin
          ch_idx <= '0;
          node   <= '0;
          sub    <= 2'd0;
          if (!started) begin
            started    <= 1'b1;
            phase      <= 2'd0;
            hold_count <= 16'd0;
          end else if (cnt_inc >= hold_ticks) begin
            hold_count <= 16'd0;
            phase      <= phase + 2'd1;
          end else begin
            hold_count <= cnt_inc;
          end
        end
        A_PAINT: begin
          levels[ch_idx] <= paint_lvl;
          changed        <= 1'b1;
          ch_idx         <= ch_idx + CH_W'(1);
          if (sub == 2'd2) begin
            sub  <= 2'd0;
            node <= node + NODE_W'(1);
          end else begin
            sub <= sub + 2'd1;
          end
        end
        A_SEND: begin
          ch_idx <= '0;
          sub    <= 2'd0;
          if (status.send_go) begin
            changed <= 1'b0;
          end
        end
        A_EMIT: begin
          if (load) begin
            out_valid <= 1'b1;
            out_data  <= emit_byte;
            out_last  <= emit_last;
            if (sub == 2'd2) begin
              sub    <= 2'd0;
              ch_idx <= ch_idx + CH_W'(1);
            end else begin
              sub <= sub + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* design/rgb_led_spi_frame_encoder.sv */
// Top level: RGB LED SPI frame encoder with configuration registers and sequencer.
//
//  channel | transaction | payload
//  --------+-------------+-------------------------------------------------
//  s_      | command in  | tuser: operation; tdata: channel, level
//  m_      | SPI byte out| tdata: spi_byte; tlast: last_byte
//  cfg_    | reg write   | cfg_index: register; cfg_data: value
//
// A channel write runs fetch, decode and write; a tick runs fetch, decode,
// test and tick, plus one paint step per channel when the palette is
// repainted; a send runs fetch, decode, test and send, plus one emit step
// per encoded byte (3 * CHANNELS); a send with no pending change ends at
// the send step. Reset clears the levels, change flag and animator and
// loads the default hold and palette. A stalled sink holds the emit step;
// the next command is taken once the last byte sits in the output register.
module rgb_led_spi_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] operation
  input  logic [15:0] s_tdata,   // [4:0] channel, [12:5] level, [15:13] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] spi_byte
  output logic        m_tlast,   // last byte of a frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import rlse_pkg::*;

  logic [15:0] hold_ticks;
  palette_t    palette;
  ctrl_t       ctrl;
  status_t     status;

  // register file is always ready; indexes past the palette are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RST;
      palette[0] <= PAL0_RST;
      palette[1] <= PAL1_RST;
      palette[2] <= PAL2_RST;
      palette[3] <= PAL3_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOLD: hold_ticks <= cfg_data[15:0];
        REG_PAL0: palette[0] <= cfg_data;
        REG_PAL1: palette[1] <= cfg_data;
        REG_PAL2: palette[2] <= cfg_data;
        REG_PAL3: palette[3] <= cfg_data;
        default:  ;
      endcase
    end
  end

  rlse_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  rlse_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .hold_ticks (hold_ticks),
    .palette    (palette)
  );

`ifndef SYNTH
  // no command is taken while a frame is being emitted
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == A_EMIT) |-> !s_tready)
    else $error("command accepted during frame emission");

  // a granted send goes straight into the emit loop
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == A_SEND && status.send_go) |=> (ctrl.act == A_EMIT))
    else $error("send did not start emission");

  // loading the final byte returns the sequencer to fetch
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == A_EMIT && status.emit_done) |=> (s_tready && m_tvalid && m_tlast))
    else $error("frame end not followed by fetch with last byte held");
`endif

endmodule
